[rtl/emr_pkg.sv]
// Shared types, constants and helpers for the elevator motion ramp.
package emr_pkg;

  localparam int EMR_FRAC_BITS = 8;

  // Item kinds
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_UP       = 3'd1;
  localparam logic [2:0] KIND_DOWN     = 3'd2;
  localparam logic [2:0] KIND_POSITION = 3'd3;
  localparam logic [2:0] KIND_FLOOR    = 3'd4;
  localparam logic [2:0] KIND_APPROACH = 3'd5;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_ACCEL_REGION    = 3'd0;
  localparam logic [2:0] REG_FLOOR_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_MIN_SPEED       = 3'd2;
  localparam logic [2:0] REG_MAX_SPEED       = 3'd3;
  localparam logic [2:0] REG_APPROACH_OFFSET = 3'd4;

  localparam logic [15:0] RST_ACCEL_REGION    = 16'd90;
  localparam logic [15:0] RST_FLOOR_HEIGHT    = 16'd900;
  localparam logic [15:0] RST_MIN_SPEED       = 16'd50;
  localparam logic [15:0] RST_MAX_SPEED       = 16'd200;
  localparam logic [15:0] RST_APPROACH_OFFSET = 16'hFECA; // -310

  // fraction*10 < 1.0 in Q0.16  <=>  fraction < 6554
  localparam logic [16:0] LEVEL_LOW_LIMIT = 17'd6554;
  localparam logic [3:0]  LEVEL_START     = 4'd1;
  localparam logic [3:0]  LEVEL_IDLE      = 4'd0;

  typedef struct packed {
    logic        [2:0]  kind;
    logic        [15:0] delta_time;
    logic signed [31:0] goal_position;
    logic signed [7:0]  floor_number;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] car_position;
    logic               is_moving;
    logic               arrived;
    logic        [3:0]  sound_level;
  } out_item_t;

  typedef struct packed {
    logic        [15:0] accel_region;
    logic        [15:0] floor_height;
    logic        [15:0] min_speed;
    logic        [15:0] max_speed;
    logic signed [15:0] approach_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic               arrived;
    logic        [3:0]  level;
  } tick_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sh0000_7FFF_FFFF;
    lo = -48'sh0000_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

[rtl/emr_tick.sv]
// Bit-serial tick datapath: two ramp divisions, speed and step multiplies.
module emr_tick import emr_pkg::*; #(
  parameter int FracBits = EMR_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] pos,
  input  logic signed [31:0] start_pos,
  input  logic signed [31:0] target,
  input  logic        [15:0] dt,
  input  cfg_t               cfg,
  output logic               done,
  output tick_res_t          res
);

  localparam int RW = 16 + FracBits;   // region width in Q
  localparam int SW = 32 - FracBits;   // step shift
  localparam logic [4:0] DIV_LAST  = 5'd16;
  localparam logic [4:0] SPD_LAST  = 5'd16;
  localparam logic [4:0] STEP_LAST = 5'd15;

  typedef enum logic [6:0] {
    T_IDLE      = 7'b0000001,
    T_PREP      = 7'b0000010,
    T_DIV_END   = 7'b0000100,
    T_DIV_START = 7'b0001000,
    T_MUL_SPD   = 7'b0010000,
    T_MUL_STEP  = 7'b0100000,
    T_FIN       = 7'b1000000
  } tstate_t;

  tstate_t state, state_next;
  logic [4:0]         cnt;
  logic [RW-1:0]      rem;
  logic [16:0]        quo;
  logic [RW-1:0]      off_s_c;
  logic [32:0]        off_end;
  logic               dir_up, dir_dn;
  logic [16:0]        a_end, a_start, a_fin;
  logic signed [47:0] acc, mcand;
  logic [16:0]        mier;

  logic [15:0]        reg_units;
  logic [RW-1:0]      region;
  logic signed [32:0] diff, sdiff;
  logic [32:0]        off_e_abs, off_s_abs;
  logic [RW:0]        dv_t;
  logic               dv_ge;
  logic [RW-1:0]      dv_rem_next;
  logic [16:0]        quo_next;
  logic [16:0]        fin_min;
  logic signed [47:0] acc_mul;
  logic [47:0]        step48;
  logic [32:0]        step_c;
  logic signed [31:0] new_pos;
  logic [20:0]        a_fin10;
  logic [3:0]         lvl;

  always_comb begin
    reg_units = (cfg.accel_region == 16'd0) ? 16'd1 : cfg.accel_region;
    region    = RW'(reg_units) << FracBits;
    diff      = 33'(target) - 33'(pos);
    sdiff     = 33'(start_pos) - 33'(pos);
    off_e_abs = diff[32] ? 33'(-diff) : 33'(diff);
    off_s_abs = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
    dv_t      = (cnt == 5'd0) ? {1'b0, rem} : {rem, 1'b0};
    dv_ge     = dv_t >= {1'b0, region};
    dv_rem_next = dv_ge ? RW'(dv_t - {1'b0, region}) : RW'(dv_t);
    quo_next  = {quo[15:0], dv_ge};
    fin_min   = (quo_next < a_end) ? quo_next : a_end;
    acc_mul   = mier[0] ? acc + mcand : acc;
    step48    = 48'(acc) >> SW;
    step_c    = (step48 > 48'(off_end)) ? off_end : step48[32:0];
    if (dir_up) new_pos = pos + step_c[31:0];
    else if (dir_dn) new_pos = pos - step_c[31:0];
    else new_pos = pos;
    a_fin10   = 21'(a_fin) * 21'd10;
    lvl = (a_start < LEVEL_LOW_LIMIT) ? LEVEL_START : 4'((a_fin10 + 21'd32768) >> 16);
  end

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE:      if (start) state_next = T_PREP;
      T_PREP:      state_next = T_DIV_END;
      T_DIV_END:   if (cnt == DIV_LAST) state_next = T_DIV_START;
      T_DIV_START: if (cnt == DIV_LAST) state_next = T_MUL_SPD;
      T_MUL_SPD:   if (cnt == SPD_LAST) state_next = T_MUL_STEP;
      T_MUL_STEP:  if (cnt == STEP_LAST) state_next = T_FIN;
      T_FIN:       state_next = T_IDLE;
      default:     state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == T_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      T_PREP: begin
        off_end <= off_e_abs;
        dir_up  <= !diff[32] && (diff != 33'sd0);
        dir_dn  <= diff[32];
        rem     <= (off_e_abs > 33'(region)) ? region : off_e_abs[RW-1:0];
        off_s_c <= (off_s_abs > 33'(region)) ? region : off_s_abs[RW-1:0];
        quo     <= '0;
        cnt     <= '0;
      end
      T_DIV_END: begin
        if (cnt == DIV_LAST) begin
          a_end <= quo_next;
          rem   <= off_s_c;
          quo   <= '0;
          cnt   <= '0;
        end else begin
          rem <= dv_rem_next;
          quo <= quo_next;
          cnt <= cnt + 5'd1;
        end
      end
      T_DIV_START: begin
        if (cnt == DIV_LAST) begin
          a_start <= quo_next;
          a_fin   <= fin_min;
          mier    <= fin_min;
          mcand   <= 48'(signed'({1'b0, cfg.max_speed}) - signed'({1'b0, cfg.min_speed}));
          acc     <= signed'(48'({cfg.min_speed, 16'd0}));
          cnt     <= '0;
        end else begin
          rem <= dv_rem_next;
          quo <= quo_next;
          cnt <= cnt + 5'd1;
        end
      end
      T_MUL_SPD: begin
        if (cnt == SPD_LAST) begin
          mier  <= {1'b0, dt};
          mcand <= acc_mul[47] ? 48'sd0 : signed'({16'd0, acc_mul[31:0]});
          acc   <= '0;
          cnt   <= '0;
        end else begin
          acc   <= acc_mul;
          mcand <= mcand <<< 1;
          mier  <= mier >> 1;
          cnt   <= cnt + 5'd1;
        end
      end
      T_MUL_STEP: begin
        acc   <= acc_mul;
        mcand <= mcand <<< 1;
        mier  <= mier >> 1;
        cnt   <= cnt + 5'd1;
      end
      T_FIN: begin
        res.position <= new_pos;
        res.arrived  <= (new_pos == target);
        res.level    <= lvl;
      end
      default: ;
    endcase
  end

endmodule

[rtl/elevator_motion_ramp.sv]
// Top level of the elevator motion ramp: config port, command decode, item handshake.
//
// Usage:
//  - req carries one in_item_t per item (valid/ready); rsp returns exactly one
//    out_item_t per accepted item, in order.
//  - Command items (up, down, to position, to floor, approach), undefined kinds and
//    ticks while the car stands still are resolved in the accept cycle; their
//    result is registered and moves to the rsp register once that is free.
//  - A tick while moving runs the bit-serial datapath: a prep step, two ramp
//    divisions, a speed multiply and a step multiply, then a finish step. The
//    result then goes through the result and rsp registers, and that serial
//    datapath sets the tick rate.
//  - One item is in work at a time; req_ready is high only while idle, but a
//    new item is taken while the previous result still waits in the rsp
//    register. A stalled receiver holds rsp and, once a second result is
//    ready, holds the block.
//  - Reset (rst, synchronous) loads the register defaults, parks the car at
//    zero, idle, and empties the rsp register.
//  - APB registers at 4*index: accel_region, floor_height, min_speed,
//    max_speed, approach_offset; write them only while the block is idle.
module elevator_motion_ramp import emr_pkg::*; #(
  parameter int FracBits = EMR_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_ready,
  input  in_item_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output out_item_t   rsp
);

  localparam int FW = 16 + FracBits;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state;
  cfg_t   cfg;
  logic signed [31:0] position, start_position, target_position;
  logic               moving;
  logic [15:0]        dt;
  out_item_t          result;
  logic               tick_start;
  logic               tick_done;
  tick_res_t          tick_res;

  // command decode
  logic               accept, slot_free, cfg_wr;
  logic signed [47:0] fh_q, tgt_flr, off_q, tgt_ext;
  logic signed [FW+8:0] flr_prod;
  logic signed [31:0] cmd_target, cmd_position;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    case (paddr[4:2])
      REG_ACCEL_REGION:    prdata = {16'd0, cfg.accel_region};
      REG_FLOOR_HEIGHT:    prdata = {16'd0, cfg.floor_height};
      REG_MIN_SPEED:       prdata = {16'd0, cfg.min_speed};
      REG_MAX_SPEED:       prdata = {16'd0, cfg.max_speed};
      REG_APPROACH_OFFSET: prdata = 32'(cfg.approach_offset);
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_region    <= RST_ACCEL_REGION;
      cfg.floor_height    <= RST_FLOOR_HEIGHT;
      cfg.min_speed       <= RST_MIN_SPEED;
      cfg.max_speed       <= RST_MAX_SPEED;
      cfg.approach_offset <= RST_APPROACH_OFFSET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ACCEL_REGION:    cfg.accel_region    <= pwdata[15:0];
        REG_FLOOR_HEIGHT:    cfg.floor_height    <= pwdata[15:0];
        REG_MIN_SPEED:       cfg.min_speed       <= pwdata[15:0];
        REG_MAX_SPEED:       cfg.max_speed       <= pwdata[15:0];
        REG_APPROACH_OFFSET: cfg.approach_offset <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Floor math in Q: floor_number * floor_height, offsets scaled by 2^FracBits.
  always_comb begin
    fh_q     = signed'(48'(FW'(cfg.floor_height) << FracBits));
    flr_prod = req.floor_number * signed'({1'b0, FW'(cfg.floor_height) << FracBits});
    tgt_flr  = 48'(flr_prod);
    off_q    = 48'(cfg.approach_offset) <<< FracBits;
    tgt_ext  = 48'(target_position);
    cmd_position = position;
    case (req.kind)
      KIND_UP:       cmd_target = sat32(tgt_ext + fh_q);
      KIND_DOWN:     cmd_target = sat32(tgt_ext - fh_q);
      KIND_POSITION: cmd_target = req.goal_position;
      KIND_FLOOR:    cmd_target = sat32(tgt_flr);
      KIND_APPROACH: begin
        cmd_target   = sat32(tgt_flr);
        cmd_position = sat32(tgt_flr + off_q);
      end
      default:       cmd_target = target_position;
    endcase
  end

  assign tick_start = accept && (req.kind == KIND_TICK) && moving;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      position        <= '0;
      start_position  <= '0;
      target_position <= '0;
      moving          <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (state == ST_HOLD && slot_free) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (tick_start) begin
            state <= ST_BUSY;
          end else if (accept) begin
            state <= ST_HOLD;
            if (req.kind >= KIND_UP && req.kind <= KIND_APPROACH) begin
              position        <= cmd_position;
              start_position  <= cmd_position;
              target_position <= cmd_target;
              moving          <= 1'b1;
            end
          end
        end
        ST_BUSY: begin
          if (tick_done) begin
            state    <= ST_HOLD;
            position <= tick_res.position;
            if (tick_res.arrived) moving <= 1'b0;
          end
        end
        ST_HOLD: begin
          if (slot_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result and payload registers
  always_ff @(posedge clk) begin
    if (tick_start) dt <= req.delta_time;
    if (state == ST_IDLE && accept && !tick_start) begin
      if (req.kind >= KIND_UP && req.kind <= KIND_APPROACH) begin
        result.car_position <= cmd_position;
        result.is_moving    <= 1'b1;
        result.sound_level  <= LEVEL_START;
      end else begin
        result.car_position <= position;
        result.is_moving    <= moving;
        result.sound_level  <= LEVEL_IDLE;
      end
      result.arrived <= 1'b0;
    end else if (state == ST_BUSY && tick_done) begin
      result.car_position <= tick_res.position;
      result.is_moving    <= !tick_res.arrived;
      result.arrived      <= tick_res.arrived;
      result.sound_level  <= tick_res.level;
    end
    if (state == ST_HOLD && slot_free) rsp <= result;
  end

  emr_tick #(.FracBits(FracBits)) u_tick (
    .clk       (clk),
    .rst       (rst),
    .start     (tick_start),
    .pos       (position),
    .start_pos (start_position),
    .target    (target_position),
    .dt        (dt),
    .cfg       (cfg),
    .done      (tick_done),
    .res       (tick_res)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    tick_done |-> state == ST_BUSY)
    else $error("tick datapath finished outside busy state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("item accepted but state stayed idle");

  a_arrive_on_target: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUSY && tick_done && tick_res.arrived) |=> position == target_position)
    else $error("arrival without position on target");

  a_arrived_stopped: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.arrived) |-> !rsp.is_moving)
    else $error("arrived item still reports moving");

endmodule

[tb/elevator_motion_ramp_tb.sv]
// Testbench for the elevator motion ramp: directed and random items checked against a predictor.
module elevator_motion_ramp_tb import emr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid = 1'b0;
  logic        req_ready;
  in_item_t    req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  out_item_t   rsp;

  elevator_motion_ramp dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the car and its settings
  logic [15:0]        m_region, m_floor_h, m_vmin, m_vmax;
  logic signed [15:0] m_appr;
  logic signed [31:0] m_pos, m_start, m_target;
  logic               m_moving;

  out_item_t expected_q[$];
  int        n_errors = 0;
  bit        hold_rsp = 1'b0;   // long receiver stall when set

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] ramp_frac(input logic [63:0] off, input logic [63:0] reg_q);
    if (off > reg_q) off = reg_q;
    return 32'((off << 16) / reg_q);
  endfunction

  // Advance the shadow car by one item and return the result it should give.
  function automatic out_item_t predict_motion(input in_item_t it);
    out_item_t          r;
    logic signed [63:0] fh_q, pos, diff, sdiff, spd, tgt;
    logic [63:0]        off_end, off_start, reg_q, step;
    logic [31:0]        a_end, a_start, a_fin;
    r = '0;
    fh_q = 64'(m_floor_h) <<< EMR_FRAC_BITS;
    if (it.kind == KIND_TICK) begin
      if (m_moving) begin
        pos = m_pos;
        diff = 64'(m_target) - pos;
        sdiff = 64'(m_start) - pos;
        off_end = diff < 0 ? -diff : diff;
        off_start = sdiff < 0 ? -sdiff : sdiff;
        reg_q = 64'(m_region == 0 ? 16'd1 : m_region) << EMR_FRAC_BITS;
        a_end = ramp_frac(off_end, reg_q);
        a_start = ramp_frac(off_start, reg_q);
        a_fin = a_end < a_start ? a_end : a_start;
        // exact speed: min speed scaled by 2^16 plus the speed span times the ramp fraction
        spd = 64'(m_vmin) * 65536 + (64'(m_vmax) - 64'(m_vmin)) * 64'(a_fin);
        if (spd < 0) spd = 0;
        step = (64'(it.delta_time) * 64'(spd)) >> (32 - EMR_FRAC_BITS);
        if (step > off_end) step = off_end;
        if (diff > 0) pos = pos + 64'(step);
        else if (diff < 0) pos = pos - 64'(step);
        m_pos = pos[31:0];
        if (64'(a_start) * 10 < 65536) r.sound_level = LEVEL_START;
        else r.sound_level = 4'((64'(a_fin) * 10 + 32768) >> 16);
        if (m_pos == m_target) begin
          m_moving = 1'b0;
          r.arrived = 1'b1;
        end
      end
    end else if (it.kind <= KIND_APPROACH) begin
      tgt = m_target;
      case (it.kind)
        KIND_UP:       tgt = clamp32(64'(m_target) + fh_q);
        KIND_DOWN:     tgt = clamp32(64'(m_target) - fh_q);
        KIND_POSITION: tgt = it.goal_position;
        KIND_FLOOR:    tgt = clamp32(64'(it.floor_number) * fh_q);
        default: begin
          tgt = 64'(it.floor_number) * fh_q;
          m_pos = clamp32(tgt + (64'(m_appr) <<< EMR_FRAC_BITS));
          tgt = clamp32(tgt);
        end
      endcase
      m_start = m_pos;
      m_target = tgt[31:0];
      m_moving = 1'b1;
      r.sound_level = LEVEL_START;
    end
    r.car_position = m_pos;
    r.is_moving = m_moving;
    return r;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ACCEL_REGION: m_region = val;
      REG_FLOOR_HEIGHT: m_floor_h = val;
      REG_MIN_SPEED:    m_vmin = val;
      REG_MAX_SPEED:    m_vmax = val;
      default:          m_appr = val;
    endcase
  endtask

  task automatic set_profile(input logic [15:0] ar, input logic [15:0] fh,
                             input logic [15:0] vlo, input logic [15:0] vhi,
                             input logic [15:0] ao);
    wait_drained();
    cfg_write(REG_ACCEL_REGION, ar);
    cfg_write(REG_FLOOR_HEIGHT, fh);
    cfg_write(REG_MIN_SPEED, vlo);
    cfg_write(REG_MAX_SPEED, vhi);
    cfg_write(REG_APPROACH_OFFSET, ao);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  int gap_pct = 25;

  task automatic random_gap();
    if ($urandom_range(99) < gap_pct) begin
      if ($urandom_range(19) == 0) repeat ($urandom_range(60, 20)) @(posedge clk);
      else repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Offer one item, hold it until accepted, queue its predicted result.
  // The block is never ready right after an accept, so the idle cycle costs nothing.
  task automatic send_item(input in_item_t it);
    random_gap();
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_q.push_back(predict_motion(it));
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_cmd(input logic [2:0] k, input logic [15:0] dt,
                                        input logic [31:0] g, input logic [7:0] f);
    in_item_t it;
    it.kind = k; it.delta_time = dt; it.goal_position = g; it.floor_number = f;
    return it;
  endfunction

  // Ticks until the car arrives, with a cap for very slow settings.
  task automatic run_ticks(input int cap, input logic [15:0] dt_lo, input logic [15:0] dt_hi);
    int n;
    n = 0;
    while (m_moving && n < cap) begin
      send_item(make_cmd(KIND_TICK, 16'($urandom_range(dt_hi, dt_lo)), $urandom,
                         8'($urandom)));
      n++;
    end
  endtask

  // Receiver: random stalls, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else if (hold_rsp) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(99) >= gap_pct) || ($urandom_range(3) == 0);
  end

  // Result checker: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (rsp.car_position !== e.car_position) begin
          $display("%0t: car_position exp %0d got %0d", $time, e.car_position,
                   rsp.car_position);
          n_errors++;
        end
        if (rsp.is_moving !== e.is_moving) begin
          $display("%0t: is_moving exp %0b got %0b", $time, e.is_moving, rsp.is_moving);
          n_errors++;
        end
        if (rsp.arrived !== e.arrived) begin
          $display("%0t: arrived exp %0b got %0b", $time, e.arrived, rsp.arrived);
          n_errors++;
        end
        if (rsp.sound_level !== e.sound_level) begin
          $display("%0t: sound_level exp %0d got %0d", $time, e.sound_level,
                   rsp.sound_level);
          n_errors++;
        end
      end
    end
  end

  // Directed: every command kind, field extremes, idle ticks, undefined kinds.
  task automatic test_directed();
    send_item(make_cmd(KIND_TICK, 16'hFFFF, 32'h0, 8'h0));          // idle tick
    send_item(make_cmd(3'd6, 16'h0, 32'hFFFF_FFFF, 8'hFF));         // undefined kind
    send_item(make_cmd(KIND_UP, 16'h0, 32'h0, 8'h0));
    send_item(make_cmd(KIND_TICK, 16'h0, 32'h0, 8'h0));             // zero step
    run_ticks(40, 16'hF000, 16'hFFFF);
    send_item(make_cmd(KIND_DOWN, 16'h0, 32'h0, 8'h0));
    send_item(make_cmd(3'd7, 16'h0, 32'h0, 8'h0));                  // undefined while moving
    run_ticks(40, 16'hF000, 16'hFFFF);
    send_item(make_cmd(KIND_POSITION, 16'h0, 32'sh7FFF_FFFF, 8'h0));
    send_item(make_cmd(KIND_POSITION, 16'h0, 32'sh8000_0000, 8'h0));
    send_item(make_cmd(KIND_FLOOR, 16'h0, 32'h0, 8'sh7F));
    send_item(make_cmd(KIND_APPROACH, 16'h0, 32'h0, 8'sh80));
    send_item(make_cmd(KIND_APPROACH, 16'h0, 32'h0, 8'sh02));
    run_ticks(15, 16'hFFFF, 16'hFFFF);
    send_item(make_cmd(KIND_POSITION, 16'h0, m_pos, 8'h0));         // already on target
    send_item(make_cmd(KIND_TICK, 16'h0, 32'h0, 8'h0));
  endtask

  // Extreme settings: saturating floors, zero ramp region, inverted speeds.
  task automatic test_extremes();
    set_profile(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'h8000);
    send_item(make_cmd(KIND_APPROACH, 16'h0, 32'h0, 8'sh7F));
    run_ticks(20, 16'h8000, 16'hFFFF);
    send_item(make_cmd(KIND_UP, 16'h0, 32'h0, 8'h0));
    send_item(make_cmd(KIND_UP, 16'h0, 32'h0, 8'h0));
    run_ticks(20, 16'hFFFF, 16'hFFFF);
    set_profile(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'h7FFF);
    send_item(make_cmd(KIND_APPROACH, 16'h0, 32'h0, 8'sh80));
    send_item(make_cmd(KIND_FLOOR, 16'h0, 32'h0, 8'sh05));
    run_ticks(20, 16'hFFFF, 16'hFFFF);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    it = make_cmd(KIND_TICK, 16'($urandom), $urandom, 8'($urandom));
    r = $urandom_range(99);
    if (r < 3) it.kind = 3'($urandom_range(7, 6));
    else if (r < 15) begin
      it.kind = 3'($urandom_range(KIND_APPROACH, KIND_UP));
      if ($urandom_range(1)) it.floor_number = 8'($urandom_range(6)) - 8'd3;
      if ($urandom_range(1)) it.goal_position = m_pos + 32'($urandom_range(8000)) - 32'd4000;
    end
    return it;
  endfunction

  // Random trips under several settings; short region keeps trips quick.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  // Receiver holds off long while ticks stack up, so the input stalls.
  task automatic test_backpressure();
    send_item(make_cmd(KIND_FLOOR, 16'h0, 32'h0, 8'sh01));
    hold_rsp = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_rsp = 1'b0;
      end
      begin
        gap_pct = 0;
        for (int i = 0; i < 8; i++) send_item(random_item());
        gap_pct = 25;
      end
    join
    // sender pauses until all results are in
    while (expected_q.size() != 0) @(posedge clk);
    test_random(20);
  endtask

  initial begin
    m_region = RST_ACCEL_REGION; m_floor_h = RST_FLOOR_HEIGHT;
    m_vmin = RST_MIN_SPEED; m_vmax = RST_MAX_SPEED; m_appr = RST_APPROACH_OFFSET;
    m_pos = '0; m_start = '0; m_target = '0; m_moving = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extremes();
    set_profile(16'd2, 16'd20, 16'd400, 16'd3000, 16'hFFF0);
    test_random(350);
    test_backpressure();
    set_profile(16'd10, 16'd60, 16'd1000, 16'd20, 16'd5);
    gap_pct = 5;
    test_random(300);
    set_profile(16'd1, 16'd8, 16'd4000, 16'd9000, 16'hFFFD);
    gap_pct = 40;
    test_random(250);
    wait_drained();
    if (n_errors == 0) $display("** elevator_motion_ramp: PASSED **");
    else $display("** elevator_motion_ramp: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** elevator_motion_ramp: FAILED **");
    $finish;
  end

endmodule
